FILE: design/bsar_pkg.sv
// Shared types and constants for the bridge converter serial reader and averager.
// Used by bsar_div and bridge_adc_serial_reader_averager; no dependencies.
package bsar_pkg;

    localparam int TIMER_W = 16;
    localparam int HALF_W  = 10;
    localparam int GAP_W   = 16;
    localparam int COUNT_W = 16;
    localparam int DIV_W   = COUNT_W + 1;   // sample count, 65536 after wrap
    localparam int OUT_W   = 24;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [HALF_W-1:0]  HALF_RESET  = 10'd30;
    localparam logic [GAP_W-1:0]   GAP_RESET   = 16'd5000;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 16'd1;
    localparam logic [DIV_W-1:0]   DIV_WRAPPED = 17'h10000;

    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP          = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 2'd2;

    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_WAIT  = 7'b0000010,
        PH_HIGH  = 7'b0000100,
        PH_LOW   = 7'b0001000,
        PH_XHIGH = 7'b0010000,
        PH_XLOW  = 7'b0100000,
        PH_GAP   = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

FILE: design/bridge_adc_serial_reader_averager.sv
// Top level: tick-driven serial reader for a 24-bit bridge converter with averaging.
// Depends on bsar_pkg and bsar_div.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------
//   s_ (in)  | s_valid / s_ready  | s_dout_level, s_start_req (one tick)
//   m_ (out) | m_valid / m_ready  | clock, sample valid/value, average
//            |                    | valid/value, busy (one per tick)
//   cfg      | cfg_wr_en          | cfg_index, cfg_wr_data
//
// A tick is taken on s_valid && s_ready; its result is registered the next cycle.
// A tick that completes an average starts the bit-serial divider; its result is
// shown once the divider is done. s_ready is low while the divider runs or while
// an unaccepted result blocks the output register. Reset is synchronous; no
// clearing pass is needed.
module bridge_adc_serial_reader_averager #(
    parameter int SAMPLE_BITS = 24
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_dout_level,
    input  logic                             s_start_req,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_clock_level,
    output logic                             m_sample_valid,
    output logic [bsar_pkg::OUT_W-1:0]       m_sample_value,
    output logic                             m_average_valid,
    output logic [bsar_pkg::OUT_W-1:0]       m_average_value,
    output logic                             m_busy_res,
    input  logic                             cfg_wr_en,
    input  logic [bsar_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bsar_pkg::CFG_W-1:0]       cfg_wr_data
);

    localparam int SUM_W     = SAMPLE_BITS + bsar_pkg::COUNT_W;
    localparam int BIT_IDX_W = $clog2(SAMPLE_BITS + 1);
    localparam int TW        = bsar_pkg::TIMER_W;

    // configuration
    logic [bsar_pkg::HALF_W-1:0]  half_reg;
    logic [bsar_pkg::GAP_W-1:0]   gap_reg;
    logic [bsar_pkg::COUNT_W-1:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_reg  <= bsar_pkg::HALF_RESET;
            gap_reg   <= bsar_pkg::GAP_RESET;
            count_reg <= bsar_pkg::COUNT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bsar_pkg::CFG_HALF_PERIOD:  half_reg  <= cfg_wr_data[bsar_pkg::HALF_W-1:0];
                bsar_pkg::CFG_GAP:          gap_reg   <= cfg_wr_data[bsar_pkg::GAP_W-1:0];
                bsar_pkg::CFG_SAMPLE_COUNT: count_reg <= cfg_wr_data[bsar_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer state
    bsar_pkg::phase_t             phase_reg, phase_next;
    logic [TW-1:0]                timer_reg, timer_next;
    logic [BIT_IDX_W-1:0]         bit_idx_reg, bit_idx_next;
    logic [SAMPLE_BITS-1:0]       shift_reg, shift_next;
    logic [SUM_W-1:0]             sum_reg, sum_next;
    logic [bsar_pkg::COUNT_W-1:0] taken_reg, taken_next;
    logic                         clk_o, smp_done, avg_done;
    logic [TW-1:0]                half_ext;

    // output register
    logic                         m_valid_reg;
    logic                         clock_level_reg, sample_valid_reg, average_valid_reg;
    logic                         busy_res_reg;
    logic [bsar_pkg::OUT_W-1:0]   sample_value_reg, average_value_reg;

    bsar_pkg::div_stat_t          div_stat;
    logic [SUM_W-1:0]             quotient;
    logic [bsar_pkg::DIV_W-1:0]   divisor;
    logic                         accept, div_start;

    assign s_ready = !div_stat.busy && !div_stat.done && (!m_valid_reg || m_ready);
    assign accept  = s_valid && s_ready;

    always_comb begin
        phase_next   = phase_reg;
        timer_next   = timer_reg;
        bit_idx_next = bit_idx_reg;
        shift_next   = shift_reg;
        sum_next     = sum_reg;
        taken_next   = taken_reg;
        clk_o        = 1'b0;
        smp_done     = 1'b0;
        avg_done     = 1'b0;
        half_ext     = TW'(half_reg);
        unique case (phase_reg)
            bsar_pkg::PH_IDLE: begin
                if (s_start_req) begin
                    sum_next   = '0;
                    taken_next = '0;
                    phase_next = bsar_pkg::PH_WAIT;
                end
            end
            bsar_pkg::PH_WAIT: begin
                if (!s_dout_level) begin
                    bit_idx_next = '0;
                    shift_next   = '0;
                    phase_next   = bsar_pkg::PH_HIGH;
                    timer_next   = TW'(1);
                    clk_o        = 1'b1;
                end
            end
            bsar_pkg::PH_HIGH, bsar_pkg::PH_XHIGH: begin
                if (timer_reg >= half_ext) begin
                    phase_next = (phase_reg == bsar_pkg::PH_HIGH) ? bsar_pkg::PH_LOW
                                                                  : bsar_pkg::PH_XLOW;
                    timer_next = TW'(1);
                end else begin
                    timer_next = timer_reg + TW'(1);
                    clk_o      = 1'b1;
                end
            end
            bsar_pkg::PH_LOW: begin
                if (timer_reg >= half_ext) begin
                    shift_next   = {shift_reg[SAMPLE_BITS-2:0], s_dout_level};
                    bit_idx_next = bit_idx_reg + BIT_IDX_W'(1);
                    if (bit_idx_next >= BIT_IDX_W'(SAMPLE_BITS)) begin
                        // last data bit: convert to offset binary
                        shift_next[SAMPLE_BITS-1] = ~shift_next[SAMPLE_BITS-1];
                        phase_next = bsar_pkg::PH_XHIGH;
                    end else begin
                        phase_next = bsar_pkg::PH_HIGH;
                    end
                    timer_next = TW'(1);
                    clk_o      = 1'b1;
                end else begin
                    timer_next = timer_reg + TW'(1);
                end
            end
            bsar_pkg::PH_XLOW: begin
                if (timer_reg >= half_ext) begin
                    sum_next   = sum_reg + SUM_W'(shift_reg);
                    taken_next = taken_reg + bsar_pkg::COUNT_W'(1);
                    smp_done   = 1'b1;
                    // a wrapped count of zero also ends the measurement
                    if (taken_next == '0 || taken_next >= count_reg) begin
                        avg_done   = 1'b1;
                        phase_next = bsar_pkg::PH_IDLE;
                    end else if (gap_reg == '0) begin
                        phase_next = bsar_pkg::PH_WAIT;
                    end else begin
                        phase_next = bsar_pkg::PH_GAP;
                    end
                    timer_next = '0;
                end else begin
                    timer_next = timer_reg + TW'(1);
                end
            end
            bsar_pkg::PH_GAP: begin
                timer_next = timer_reg + TW'(1);
                if (timer_next >= TW'(gap_reg)) begin
                    phase_next = bsar_pkg::PH_WAIT;
                    timer_next = '0;
                end
            end
            default: phase_next = bsar_pkg::PH_IDLE;
        endcase
    end

    assign divisor   = (taken_next == '0) ? bsar_pkg::DIV_WRAPPED
                                          : {1'b0, taken_next};
    assign div_start = accept && avg_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= bsar_pkg::PH_IDLE;
            timer_reg   <= '0;
            bit_idx_reg <= '0;
            shift_reg   <= '0;
            sum_reg     <= '0;
            taken_reg   <= '0;
        end else if (accept) begin
            phase_reg   <= phase_next;
            timer_reg   <= timer_next;
            bit_idx_reg <= bit_idx_next;
            shift_reg   <= shift_next;
            sum_reg     <= sum_next;
            taken_reg   <= taken_next;
        end
    end

    bsar_div #(
        .DIVIDEND_W (SUM_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_next),
        .divisor  (divisor),
        .stat     (div_stat),
        .quotient (quotient)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            // an averaging tick waits for the divider before it is shown
            m_valid_reg <= !avg_done;
        end else if (div_stat.done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            clock_level_reg   <= clk_o;
            sample_valid_reg  <= smp_done;
            sample_value_reg  <= smp_done ? bsar_pkg::OUT_W'(shift_reg) : '0;
            average_valid_reg <= avg_done;
            average_value_reg <= '0;
            busy_res_reg      <= (phase_next != bsar_pkg::PH_IDLE);
        end else if (div_stat.done) begin
            average_value_reg <= bsar_pkg::OUT_W'(quotient);
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_clock_level   = clock_level_reg;
    assign m_sample_valid  = sample_valid_reg;
    assign m_sample_value  = sample_value_reg;
    assign m_average_valid = average_valid_reg;
    assign m_average_value = average_value_reg;
    assign m_busy_res      = busy_res_reg;

`ifndef NO_ASSERTIONS
    a_no_result_during_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> !m_valid_reg)
        else $error("result shown while divider runs");

    a_done_shows_result: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.done |=> m_valid_reg)
        else $error("divider finished but no result shown");

    a_no_accept_during_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_stat.busy || div_stat.done) |-> !s_ready)
        else $error("tick accepted while average pending");

    a_average_with_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && average_valid_reg) |-> (sample_valid_reg && !busy_res_reg))
        else $error("average without closing sample");
`endif

endmodule

FILE: design/bsar_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bsar_pkg (DIV_W, div_stat_t).
module bsar_div #(
    parameter int DIVIDEND_W = 40
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [DIVIDEND_W-1:0]    dividend,
    input  logic [bsar_pkg::DIV_W-1:0] divisor,
    output bsar_pkg::div_stat_t      stat,
    output logic [DIVIDEND_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                        busy_reg, done_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic [DIVIDEND_W-1:0]       dvd_reg;
    logic [bsar_pkg::DIV_W-1:0]  dsr_reg, rem_reg;
    logic [bsar_pkg::DIV_W:0]    trial;
    logic [bsar_pkg::DIV_W-1:0]  diff;
    logic                        qbit;
    logic [bsar_pkg::DIV_W-1:0]  rem_next;

    // the difference is only kept when it fits, so its low bits are enough
    always_comb begin
        trial    = {rem_reg, dvd_reg[DIVIDEND_W-1]};
        diff     = trial[bsar_pkg::DIV_W-1:0] - dsr_reg;
        qbit     = (trial >= {1'b0, dsr_reg});
        rem_next = qbit ? diff : trial[bsar_pkg::DIV_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIVIDEND_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dividend shifts out the top while quotient bits enter at the bottom
    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DIVIDEND_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = dvd_reg;

endmodule
